// ----- design/pbd_pkg.sv -----
// Package for the parallel bit extract/deposit core.
// Word geometry, stage payload structs. No dependencies.
package pbd_pkg;

  localparam int WB  = 64;             // datapath word width
  localparam int LG  = $clog2(WB);     // shift levels, also distance width
  localparam int GB  = 8;              // bits per prefix-count group
  localparam int NG  = WB / GB;        // number of groups
  localparam int LW  = $clog2(GB);     // in-group offset width
  localparam int TW  = $clog2(GB) + 1; // group total width
  localparam int LPS = 2;              // shift levels per pipeline stage
  localparam int NCS = LG / LPS;       // stages in each shift network

  typedef logic [WB-1:0] word_t;
  typedef logic [WB-1:0][LG-1:0] dist_vec_t;
  typedef logic [LG-1:0][WB-1:0] move_t;

  typedef enum logic {
    ACT_EXTRACT = 1'b0,
    ACT_DEPOSIT = 1'b1
  } action_t;

  // Payload through the compress network
  typedef struct packed {
    action_t   act;
    word_t     occ;   // occupied positions (mask bits as they move)
    word_t     dat;   // extract: data being packed; deposit: raw value
    dist_vec_t shamt; // remaining right-shift distance per position
    move_t     mv;    // per-level move bitmaps, replayed by expand
  } cmp_t;

  // Payload through the expand network
  typedef struct packed {
    action_t act;
    word_t   dat;
    move_t   mv;
  } exp_t;

endpackage

// ----- design/pbd_req_if.sv -----
// Request channel for the bit extract/deposit core.
// Depends on pbd_pkg.
interface pbd_req_if import pbd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  word_t value;
  word_t mask;

  modport source (output valid, action, value, mask, input ready);
  modport sink   (input valid, action, value, mask, output ready);
endinterface

// ----- design/pbd_rsp_if.sv -----
// Result channel for the bit extract/deposit core.
// Depends on pbd_pkg.
interface pbd_rsp_if import pbd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// ----- design/pbd_prefix.sv -----
// Two pipeline stages: per-position count of clear mask bits below it.
// Depends on pbd_pkg.
module pbd_prefix import pbd_pkg::*; (
  input  logic       clk,
  input  logic [1:0] ld,
  input  logic       act,
  input  word_t      val,
  input  word_t      msk,
  output cmp_t       q
);

  logic                       act1;
  word_t                      val1;
  word_t                      msk1;
  logic [NG-1:0][GB-1:0][LW-1:0] loc_next, loc1;
  logic [NG-1:0][TW-1:0]      tot_next, tot1;
  cmp_t                       q_next;

  // stage 1: in-group zero counts
  always_comb begin
    logic [TW-1:0] cnt;
    cnt = '0;
    for (int g = 0; g < NG; g++) begin
      cnt = '0;
      for (int b = 0; b < GB; b++) begin
        loc_next[g][b] = cnt[LW-1:0];
        cnt = cnt + {{(TW-1){1'b0}}, ~msk[g*GB+b]};
      end
      tot_next[g] = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      act1 <= act;
      val1 <= val;
      msk1 <= msk;
      loc1 <= loc_next;
      tot1 <= tot_next;
    end
  end

  // stage 2: group offsets plus in-group counts
  always_comb begin
    logic [LG-1:0] off;
    off = '0;
    q_next.act = action_t'(act1);
    q_next.occ = msk1;
    q_next.dat = act1 ? val1 : (val1 & msk1);
    q_next.mv  = '0;
    for (int g = 0; g < NG; g++) begin
      for (int b = 0; b < GB; b++) begin
        q_next.shamt[g*GB+b] = off + {{(LG-LW){1'b0}}, loc1[g][b]};
      end
      off = off + {{(LG-TW){1'b0}}, tot1[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      q <= q_next;
    end
  end

endmodule

// ----- design/pbd_compress.sv -----
// One compress stage: LPS right-shift levels, low level first.
// Records move bitmaps for the expand network. Depends on pbd_pkg.
module pbd_compress import pbd_pkg::*; #(
  parameter int LVL_LO = 0
) (
  input  logic clk,
  input  logic ld,
  input  cmp_t d,
  output cmp_t q
);

  cmp_t q_next;

  always_comb begin
    cmp_t c;
    cmp_t n;
    int   j;
    int   s;
    logic stay;
    logic arr;
    c = d;
    n = d;
    for (int k = 0; k < LPS; k++) begin
      j = LVL_LO + k;
      s = 1 << j;
      n = c;
      for (int p = 0; p < WB; p++) begin
        n.mv[j][p] = c.occ[p] & c.shamt[p][j];
        stay = c.occ[p] & ~c.shamt[p][j];
        if (p + s < WB) begin
          arr = c.occ[p+s] & c.shamt[p+s][j];
          n.shamt[p] = arr ? c.shamt[p+s] : c.shamt[p];
          n.dat[p]  = (c.act == ACT_DEPOSIT) ? c.dat[p]
                    : ((stay & c.dat[p]) | (arr & c.dat[p+s]));
        end else begin
          arr = 1'b0;
          n.dat[p] = (c.act == ACT_DEPOSIT) ? c.dat[p] : (stay & c.dat[p]);
        end
        n.occ[p] = stay | arr;
      end
      c = n;
    end
    q_next = c;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      q <= q_next;
    end
  end

endmodule

// ----- design/pbd_expand.sv -----
// One expand stage: replays LPS compress levels in reverse, shifting left.
// Depends on pbd_pkg.
module pbd_expand import pbd_pkg::*; #(
  parameter int LVL_HI = 5
) (
  input  logic clk,
  input  logic ld,
  input  exp_t d,
  output exp_t q
);

  exp_t q_next;

  always_comb begin
    word_t x;
    word_t tgt;
    int    j;
    int    s;
    x = d.dat;
    for (int k = 0; k < LPS; k++) begin
      j   = LVL_HI - k;
      s   = 1 << j;
      tgt = d.mv[j] >> s;
      if (d.act == ACT_DEPOSIT) begin
        x = (x & ~tgt) | ((x & tgt) << s);
      end
    end
    q_next     = d;
    q_next.dat = x;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      q <= q_next;
    end
  end

endmodule

// ----- design/parallel_bit_extract_deposit_core.sv -----
// Top level of the parallel bit extract/deposit core.
// Depends on pbd_pkg, pbd_req_if, pbd_rsp_if, pbd_prefix, pbd_compress, pbd_expand.
//
//   channel | dir | fields                 | notes
//   --------+-----+------------------------+-----------------------------------
//   req     | in  | action, value, mask    | action 0 = extract, 1 = deposit
//   rsp     | out | result                 | one result per request, in order
//
// Flow: one request per cycle sustained while rsp.ready is high; the accepting edge loads stage 1
//   of 8 (2 prefix-count, 3 compress, 3 expand), and rsp.valid rises once the item reaches stage 8.
// Reset: rst clears only the stage valid bits; payload registers are not reset.
// Stalls: each stage loads when it is empty or the stage after it moves, so
//   bubbles are squeezed out and req.ready stays high while any stage is free.
module parallel_bit_extract_deposit_core import pbd_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  pbd_req_if.sink     req,
  pbd_rsp_if.source   rsp
);

  localparam int    NS        = 2 + 2 * NCS;  // total pipeline stages
  localparam int    ACT_BITS  = (WORD_BITS > WB) ? WB : WORD_BITS;  // wider acts as WB
  localparam word_t WORD_MASK = {WB{1'b1}} >> (WB - ACT_BITS);

  logic [NS-1:0] v;      // stage valid bits
  logic [NS:0]   rdy;    // stage k may load
  logic [NS-1:0] vin;    // valid presented to each stage

  cmp_t cst [0:NCS];
  exp_t est [0:NCS];

  // Ready ripples back from the result port; an empty stage always loads.
  assign rdy[NS] = rsp.ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end

  assign vin = {v[NS-2:0], req.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  assign req.ready = rdy[0];

  // Zero-count prefix: distance each mask bit travels when packed low.
  pbd_prefix u_prefix (
    .clk (clk),
    .ld  (rdy[1:0]),
    .act (req.action),
    .val (req.value & WORD_MASK),
    .msk (req.mask & WORD_MASK),
    .q   (cst[0])
  );

  // Compress network, low shift levels first. Extract packs the data here;
  // deposit only packs the mask to learn the moves.
  for (genvar g = 0; g < NCS; g++) begin : g_cmp
    pbd_compress #(.LVL_LO(g * LPS)) u_cmp (
      .clk (clk),
      .ld  (rdy[2+g]),
      .d   (cst[g]),
      .q   (cst[g+1])
    );
  end

  // Deposit keeps only the low popcount(mask) value bits, which the packed
  // occupancy marks exactly, then runs the compress moves backwards.
  assign est[0].act = cst[NCS].act;
  assign est[0].dat = (cst[NCS].act == ACT_DEPOSIT) ? (cst[NCS].dat & cst[NCS].occ)
                                                    : cst[NCS].dat;
  assign est[0].mv  = cst[NCS].mv;

  for (genvar g = 0; g < NCS; g++) begin : g_exp
    pbd_expand #(.LVL_HI(LG - 1 - g * LPS)) u_exp (
      .clk (clk),
      .ld  (rdy[2+NCS+g]),
      .d   (est[g]),
      .q   (est[g+1])
    );
  end

  assign rsp.valid  = v[NS-1];
  assign rsp.result = est[NCS].dat & WORD_MASK;

  // After the compress network the occupied positions form a block at the low end.
  a_occ_packed: assert property (@(posedge clk) disable iff (rst)
    v[1+NCS] |-> ((cst[NCS].occ & (cst[NCS].occ + 1'b1)) == '0))
    else $error("compressed occupancy not packed low");

  // Extracted data never sits outside the packed occupancy.
  a_ext_confined: assert property (@(posedge clk) disable iff (rst)
    (v[1+NCS] && (cst[NCS].act == ACT_EXTRACT)) |-> ((cst[NCS].dat & ~cst[NCS].occ) == '0))
    else $error("extract data outside occupied positions");

  // Items in flight change only by requests taken and results delivered.
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(v) == $past($countones(v))
                              + int'($past(req.valid & req.ready))
                              - int'($past(rsp.valid & rsp.ready))))
    else $error("pipeline dropped or duplicated an item");

endmodule
